FILE: rtl/spli_pkg.sv
package spli_pkg;

  localparam int unsigned ID_W = 31;

  localparam logic [1:0] CMD_APPEND_FIRST  = 2'd0;
  localparam logic [1:0] CMD_APPEND_SECOND = 2'd1;
  localparam logic [1:0] CMD_RUN           = 2'd2;
  localparam logic [1:0] CMD_CLEAR         = 2'd3;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [ID_W-1:0] doc_id;
  } req_t;

  typedef struct packed {
    logic            status;
    logic            has_match;
    logic [ID_W-1:0] match_id;
    logic            last_of_run;
  } rsp_t;

  typedef struct packed {
    logic wr_first;
    logic wr_second;
    logic clr;
    logic start;
    logic advance;
    logic load_pend;
    logic push_pend;
    logic push_final;
    logic push_resp;
  } spli_cmd_t;

  typedef struct packed {
    logic active;
    logic ids_eq;
    logic pend_valid;
    logic out_free;
  } spli_stat_t;

endpackage

FILE: rtl/spli_ctrl.sv
module spli_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic [1:0]          req_cmd,
  output logic                req_ready,
  input  spli_pkg::spli_stat_t stat,
  output spli_pkg::spli_cmd_t  cmd
);
  import spli_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_WALK   = 4'b0010,
    S_FINISH = 4'b0100,
    S_RESP   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (req_cmd)
            CMD_APPEND_FIRST: begin
              cmd.wr_first = 1'b1;
              state_next   = S_RESP;
            end
            CMD_APPEND_SECOND: begin
              cmd.wr_second = 1'b1;
              state_next    = S_RESP;
            end
            CMD_RUN: begin
              cmd.start  = 1'b1;
              state_next = S_WALK;
            end
            CMD_CLEAR: begin
              cmd.clr    = 1'b1;
              state_next = S_RESP;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_WALK: begin
        if (!stat.active) begin
          state_next = S_FINISH;
        end else if (stat.ids_eq) begin
          // hold while the previous match cannot leave
          if (!stat.pend_valid || stat.out_free) begin
            cmd.advance   = 1'b1;
            cmd.load_pend = 1'b1;
            cmd.push_pend = stat.pend_valid;
          end
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.push_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.push_resp = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/spli_datapath.sv
module spli_datapath #(
  parameter int unsigned LIST_DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [spli_pkg::ID_W-1:0]  doc_id,
  input  spli_pkg::spli_cmd_t        cmd,
  output spli_pkg::spli_stat_t       stat,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output spli_pkg::rsp_t             rsp
);
  import spli_pkg::*;

  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

  logic [ID_W-1:0] mem_first  [LIST_DEPTH];
  logic [ID_W-1:0] mem_second [LIST_DEPTH];

  logic [CW-1:0]   cnt_first;
  logic [CW-1:0]   cnt_second;
  logic [CW-1:0]   ptr_i;
  logic [CW-1:0]   ptr_j;
  logic [CW-1:0]   ptr_i_next;
  logic [CW-1:0]   ptr_j_next;
  logic [AW-1:0]   addr_i;
  logic [AW-1:0]   addr_j;
  logic [ID_W-1:0] rd_first;
  logic [ID_W-1:0] rd_second;
  logic            full_first;
  logic            full_second;
  logic            ids_eq;
  logic            first_lt;
  logic            resp_status;
  logic            pend_valid;
  logic [ID_W-1:0] pend_id;
  logic            out_free;

  assign full_first  = (cnt_first == CW'(LIST_DEPTH));
  assign full_second = (cnt_second == CW'(LIST_DEPTH));
  assign ids_eq      = (rd_first == rd_second);
  assign first_lt    = (rd_first < rd_second);
  assign out_free    = !rsp_valid || rsp_ready;

  assign ptr_i_next = ptr_i + CW'(ids_eq || first_lt);
  assign ptr_j_next = ptr_j + CW'(ids_eq || !first_lt);

  always_comb begin
    if (cmd.start) begin
      addr_i = '0;
      addr_j = '0;
    end else if (cmd.advance) begin
      addr_i = ptr_i_next[AW-1:0];
      addr_j = ptr_j_next[AW-1:0];
    end else begin
      addr_i = ptr_i[AW-1:0];
      addr_j = ptr_j[AW-1:0];
    end
  end

  assign stat.active     = (ptr_i < cnt_first) && (ptr_j < cnt_second);
  assign stat.ids_eq     = ids_eq;
  assign stat.pend_valid = pend_valid;
  assign stat.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (cmd.wr_first && !full_first) begin
      mem_first[cnt_first[AW-1:0]] <= doc_id;
    end
    rd_first <= mem_first[addr_i];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_second && !full_second) begin
      mem_second[cnt_second[AW-1:0]] <= doc_id;
    end
    rd_second <= mem_second[addr_j];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_first  <= '0;
      cnt_second <= '0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.clr) begin
        cnt_first  <= '0;
        cnt_second <= '0;
      end else begin
        if (cmd.wr_first && !full_first) begin
          cnt_first <= cnt_first + CW'(1);
        end
        if (cmd.wr_second && !full_second) begin
          cnt_second <= cnt_second + CW'(1);
        end
      end
      if (cmd.start) begin
        pend_valid <= 1'b0;
      end else if (cmd.load_pend) begin
        pend_valid <= 1'b1;
      end
      if (cmd.push_pend || cmd.push_final || cmd.push_resp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ptr_i <= '0;
      ptr_j <= '0;
    end else if (cmd.advance) begin
      ptr_i <= ptr_i_next;
      ptr_j <= ptr_j_next;
    end
    if (cmd.load_pend) begin
      pend_id <= rd_first;
    end
    if (cmd.wr_first) begin
      resp_status <= full_first;
    end else if (cmd.wr_second) begin
      resp_status <= full_second;
    end else if (cmd.clr) begin
      resp_status <= 1'b0;
    end
    if (cmd.push_pend) begin
      rsp <= '{status: 1'b0, has_match: 1'b1, match_id: pend_id, last_of_run: 1'b0};
    end else if (cmd.push_final) begin
      rsp <= '{status: 1'b0, has_match: pend_valid,
               match_id: pend_valid ? pend_id : '0, last_of_run: 1'b1};
    end else if (cmd.push_resp) begin
      rsp <= '{status: resp_status, has_match: 1'b0, match_id: '0, last_of_run: 1'b1};
    end
  end

endmodule

FILE: rtl/sorted_posting_list_intersect.sv
// channel | signals                     | item   | accepted when
// req     | req_valid, req_ready, req   | req_t  | req_valid && req_ready
// rsp     | rsp_valid, rsp_ready, rsp   | rsp_t  | rsp_valid && rsp_ready
//
// Append, clear: accepted in idle; the response state then loads the response register once the output side is free.
// Run: start, one pointer step per walk state unless a stall holds it, end check, finish; at most
// 2*LIST_DEPTH-1 steps through the two list RAMs, each with one registered read port.
// One request is in work at a time; a response register frees the output side.
// Reset clears both counts, the controller and the response valid.
// A stalled rsp holds the walk only when a second match needs the register.
module sorted_posting_list_intersect #(
  parameter int unsigned LIST_DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  spli_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output spli_pkg::rsp_t  rsp
);
  import spli_pkg::*;

  spli_cmd_t  cmd;
  spli_stat_t stat;

  spli_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_cmd   (req.cmd),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spli_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .doc_id    (req.doc_id),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

FILE: rtl/spli_check.sv
module spli_check (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input spli_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input spli_pkg::rsp_t rsp
);
  import spli_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while another is in work");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_no_match_form: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.has_match |-> rsp.match_id == '0 && rsp.last_of_run)
    else $error("bad response without match");

  a_match_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.has_match |-> !rsp.status)
    else $error("match carries error status");

  a_full_form: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status |-> !rsp.has_match && rsp.last_of_run)
    else $error("bad full-list response");

endmodule

bind sorted_posting_list_intersect spli_check u_check (.*);

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import spli_pkg::*;

  localparam int LIST_DEPTH = 64;
  localparam int ITEM_TARGET = 410;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 2 * LIST_DEPTH + 16;
  localparam logic [ID_W-1:0] MAX_ID = '1;

  typedef struct packed {
    logic drain;
    req_t item;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  stim_t stim_q[$];
  rsp_t answer_q[$];
  rsp_t want;
  logic [ID_W-1:0] first_ids[LIST_DEPTH];
  logic [ID_W-1:0] second_ids[LIST_DEPTH];
  int first_len = 0;
  int second_len = 0;
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_cnt = 0;

  sorted_posting_list_intersect #(.LIST_DEPTH(LIST_DEPTH)) uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [ID_W-1:0] rand_id();
    return ID_W'($urandom);
  endfunction

  task automatic add_item(input logic [1:0] cmd, input logic [ID_W-1:0] id,
                          input logic drain);
    stim_t s;
    s.drain = drain;
    s.item.cmd = cmd;
    s.item.doc_id = id;
    stim_q.push_back(s);
  endtask

  task automatic post_request(input req_t r);
    rsp_t ack;
    rsp_t held;
    logic have_held;
    int i;
    int j;
    ack = '0;
    ack.last_of_run = 1'b1;
    held = '0;
    have_held = 1'b0;
    i = 0;
    j = 0;
    case (r.cmd)
      CMD_APPEND_FIRST: begin
        if (first_len >= LIST_DEPTH) begin
          ack.status = 1'b1;
        end else begin
          first_ids[first_len] = r.doc_id;
          first_len++;
        end
        answer_q.push_back(ack);
      end
      CMD_APPEND_SECOND: begin
        if (second_len >= LIST_DEPTH) begin
          ack.status = 1'b1;
        end else begin
          second_ids[second_len] = r.doc_id;
          second_len++;
        end
        answer_q.push_back(ack);
      end
      CMD_CLEAR: begin
        first_len = 0;
        second_len = 0;
        answer_q.push_back(ack);
      end
      default: begin
        while (i < first_len && j < second_len) begin
          if (first_ids[i] == second_ids[j]) begin
            if (have_held) answer_q.push_back(held);
            held = '0;
            held.has_match = 1'b1;
            held.match_id = first_ids[i];
            have_held = 1'b1;
            i++;
            j++;
          end else if (first_ids[i] < second_ids[j]) begin
            i++;
          end else begin
            j++;
          end
        end
        if (have_held) begin
          held.last_of_run = 1'b1;
          answer_q.push_back(held);
        end else begin
          answer_q.push_back(ack);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) post_request(req);
      if (req_valid && !req_ready) begin
        // hold the item until accepted
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        req_valid <= 1'b0;
      end else if (stim_q.size() == 0 || (stim_q[0].drain && answer_q.size() != 0)) begin
        req_valid <= 1'b0;
      end else begin
        req_valid <= 1'b1;
        req <= stim_q[0].item;
        stim_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (answer_q.size() == 0) begin
          $error("unexpected item: %p", rsp);
          errors++;
        end else begin
          want = answer_q.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            errors++;
          end
          if (rsp.has_match !== want.has_match) begin
            $error("has_match: expected %0d, got %0d", want.has_match, rsp.has_match);
            errors++;
          end
          if (rsp.match_id !== want.match_id) begin
            $error("match_id: expected %0h, got %0h", want.match_id, rsp.match_id);
            errors++;
          end
          if (rsp.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                   rsp.last_of_run);
            errors++;
          end
        end
      end
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt % 150 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: rsp_ready <= 1'b1;
        1: rsp_ready <= 1'($urandom_range(0, 1));
        2: rsp_ready <= (stall_cnt % 4 == 0);
        default: rsp_ready <= (stall_cnt % 12 < 2);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [ID_W-1:0] base;
    int n;
    int pick;
    int span;
    int kind;

    add_item(CMD_RUN, MAX_ID, 1'b0);
    add_item(CMD_APPEND_FIRST, '0, 1'b0);
    add_item(CMD_RUN, '0, 1'b0);
    add_item(CMD_APPEND_SECOND, '0, 1'b0);
    add_item(CMD_APPEND_FIRST, MAX_ID, 1'b0);
    add_item(CMD_APPEND_SECOND, 31'd5, 1'b0);
    add_item(CMD_APPEND_SECOND, MAX_ID, 1'b0);
    add_item(CMD_RUN, rand_id(), 1'b0);
    add_item(CMD_CLEAR, MAX_ID, 1'b1);
    add_item(CMD_RUN, rand_id(), 1'b0);
    // unsorted first list
    add_item(CMD_APPEND_FIRST, 31'd10, 1'b0);
    add_item(CMD_APPEND_FIRST, 31'd3, 1'b0);
    add_item(CMD_APPEND_FIRST, 31'd7, 1'b0);
    add_item(CMD_APPEND_SECOND, 31'd3, 1'b0);
    add_item(CMD_APPEND_SECOND, 31'd7, 1'b0);
    add_item(CMD_APPEND_SECOND, 31'd10, 1'b0);
    add_item(CMD_RUN, rand_id(), 1'b0);
    add_item(CMD_CLEAR, rand_id(), 1'b0);
    add_item(CMD_APPEND_FIRST, 31'd4, 1'b0);
    add_item(CMD_APPEND_FIRST, 31'd8, 1'b0);
    add_item(CMD_APPEND_SECOND, 31'd5, 1'b0);
    add_item(CMD_APPEND_SECOND, 31'd9, 1'b0);
    add_item(CMD_RUN, rand_id(), 1'b0);

    // fill both lists, overflow them, then match every entry
    add_item(CMD_CLEAR, rand_id(), 1'b1);
    base = ID_W'($urandom_range(0, 32'h3FFF_FFFF));
    for (int k = 0; k < LIST_DEPTH; k++) begin
      add_item(CMD_APPEND_FIRST, base, 1'b0);
      add_item(CMD_APPEND_SECOND, base, 1'b0);
      base = base + ID_W'($urandom_range(1, 50));
    end
    add_item(CMD_APPEND_FIRST, rand_id(), 1'b0);
    add_item(CMD_APPEND_SECOND, rand_id(), 1'b0);
    add_item(CMD_RUN, rand_id(), 1'b0);

    while (stim_q.size() < ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        if ($urandom_range(0, 4) != 0) add_item(CMD_CLEAR, rand_id(), 1'b0);
        n = $urandom_range(0, 14);
        base = ID_W'($urandom_range(0, 32'h7FFF_0000));
        span = ($urandom_range(0, 1) == 1) ? 3 : 1000;
        for (int k = 0; k < n; k++) begin
          pick = $urandom_range(0, 2);
          if (pick != 1) add_item(CMD_APPEND_FIRST, base, 1'b0);
          if (pick != 0) add_item(CMD_APPEND_SECOND, base, 1'b0);
          base = base + ID_W'($urandom_range(1, span));
        end
        repeat ($urandom_range(1, 2))
          add_item(CMD_RUN, rand_id(), $urandom_range(0, 7) == 0);
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 6)) add_item(2'($urandom), rand_id(), 1'b0);
      end else begin
        add_item(2'($urandom_range(0, 1)), rand_id(), 1'b0);
        add_item(CMD_RUN, rand_id(), 1'b0);
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (stim_q.size() != 0 || req_valid) @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
